>>> design/ctss_pkg.sv
package ctss_pkg;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_BUSY = 4'b0010,
    PH_PASS = 4'b0100,
    PH_FAIL = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    RQ_NONE  = 2'd0,
    RQ_WRITE = 2'd1,
    RQ_READ  = 2'd2,
    RQ_PIN   = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    RS_BUSY = 2'd0,
    RS_PASS = 2'd1,
    RS_FAIL = 2'd2
  } run_status_e;

  localparam logic [2:0] StLevel    = 3'd0;
  localparam logic [2:0] StPin      = 3'd1;
  localparam logic [2:0] StStart    = 3'd2;
  localparam logic [2:0] StDir      = 3'd3;
  localparam logic [2:0] StCode     = 3'd4;
  localparam logic [2:0] StCompare  = 3'd5;
  localparam logic [2:0] StReadback = 3'd6;
  localparam logic [2:0] StLast     = 3'd6;

  localparam logic       CmdStart   = 1'b0;

  localparam logic       CfgCalib   = 1'b0;
  localparam logic       CfgUpper   = 1'b1;

  localparam logic [15:0] AddrLevel = 16'h1047;
  localparam logic [15:0] AddrTune  = 16'h1049;
  localparam logic [15:0] AddrComp  = 16'h1045;
  localparam logic [7:0]  StartCode = 8'h0f;
  localparam logic [7:0]  LevelMask = 8'h07;
  localparam logic [7:0]  UpperMask = 8'hf8;
  localparam logic [4:0]  UpLimit   = 5'd16;
  localparam logic [4:0]  DownLimit = 5'd15;
  localparam int unsigned FlagBit   = 5;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  step;
    logic        down;
    logic [4:0]  offset;
    logic [15:0] saved;
  } ctss_state_t;

  typedef struct packed {
    req_kind_e   kind;
    logic [15:0] addr;
    logic [7:0]  wbyte;
    run_status_e status;
    logic [7:0]  trim_low;
    logic [7:0]  trim_high;
  } ctss_res_t;

endpackage

>>> design/ctss_step.sv
module ctss_step
  import ctss_pkg::*;
(
  input  ctss_state_t state_i,
  input  logic [2:0]  calib_level_i,
  input  logic [7:0]  upper_voltage_bits_i,
  input  logic        cmd_i,
  input  logic        status_ok_i,
  input  logic [7:0]  read_low_i,
  input  logic [7:0]  read_high_i,
  output ctss_state_t state_o,
  output logic        res_valid_o,
  output ctss_res_t   res_o
);

  logic       flag;
  logic       none_req;
  logic [7:0] code;
  logic [4:0] limit;

  assign flag  = read_low_i[FlagBit];
  assign limit = state_i.down ? DownLimit : UpLimit;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b1;
    none_req    = 1'b0;
    if (cmd_i == CmdStart) begin
      state_o.phase  = PH_BUSY;
      state_o.step   = StLevel;
      state_o.down   = 1'b0;
      state_o.offset = '0;
      state_o.saved  = '0;
    end else if (state_i.phase != PH_BUSY) begin
      res_valid_o = 1'b0;
    end else if (state_i.step == StPin) begin
      state_o.step = StStart;
    end else if (state_i.step > StLast) begin
      state_o.phase = PH_FAIL;
      none_req      = 1'b1;
    end else if (status_ok_i) begin
      case (state_i.step)
        StLevel, StStart, StCode: begin
          state_o.step = state_i.step + 3'd1;
        end
        StDir: begin
          state_o.down   = ~flag;
          state_o.offset = 5'd1;
          state_o.step   = StCode;
        end
        StCompare: begin
          if (state_i.down ? flag : ~flag) begin
            state_o.step = StReadback;
          end else if (state_i.offset < limit) begin
            state_o.offset = state_i.offset + 5'd1;
            state_o.step   = StCode;
          end else begin
            state_o.phase = PH_FAIL;
            none_req      = 1'b1;
          end
        end
        default: begin
          state_o.saved = {read_high_i, read_low_i};
          state_o.phase = PH_PASS;
          state_o.step  = StLevel;
          none_req      = 1'b1;
        end
      endcase
    end
  end

  // trim code for the search step
  always_comb begin
    if (state_o.down) begin
      code = StartCode - {3'd0, state_o.offset};
    end else begin
      code = StartCode + {3'd0, state_o.offset};
    end
  end

  always_comb begin
    res_o.kind  = RQ_NONE;
    res_o.addr  = '0;
    res_o.wbyte = '0;
    if (!none_req) begin
      case (state_o.step)
        StLevel: begin
          res_o.kind  = RQ_WRITE;
          res_o.addr  = AddrLevel;
          res_o.wbyte = ({5'd0, calib_level_i} & LevelMask) | (upper_voltage_bits_i & UpperMask);
        end
        StPin: begin
          res_o.kind = RQ_PIN;
        end
        StStart: begin
          res_o.kind  = RQ_WRITE;
          res_o.addr  = AddrTune;
          res_o.wbyte = StartCode;
        end
        StDir, StCompare: begin
          res_o.kind = RQ_READ;
          res_o.addr = AddrComp;
        end
        StCode: begin
          res_o.kind  = RQ_WRITE;
          res_o.addr  = AddrTune;
          res_o.wbyte = code;
        end
        StReadback: begin
          res_o.kind = RQ_READ;
          res_o.addr = AddrTune;
        end
        default: begin
          res_o.kind = RQ_NONE;
        end
      endcase
    end
    case (state_o.phase)
      PH_PASS: res_o.status = RS_PASS;
      PH_FAIL: res_o.status = RS_FAIL;
      default: res_o.status = RS_BUSY;
    endcase
    res_o.trim_low  = state_o.saved[7:0];
    res_o.trim_high = state_o.saved[15:8];
  end

endmodule

>>> design/comparator_trim_search_sequencer.sv
// Comparator trim search sequencer. Each input beat (a start command or the
// completion of the last request) yields at most one request beat; a completion
// while no run is active yields none. One beat is taken per clock while input stall is low: a beat goes
// into the input register, then the step logic updates the sequence state and
// fills the result register, from which the request is presented. The result
// register holds a stalled request while the input register takes the next beat;
// input stall rises only when both are full and the output is stalled.
module comparator_trim_search_sequencer
  import ctss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic        status_ok_i,
  input  logic [7:0]  read_low_i,
  input  logic [7:0]  read_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  request_kind_o,
  output logic [15:0] reg_address_o,
  output logic [7:0]  write_byte_o,
  output logic [1:0]  run_status_o,
  output logic [7:0]  trim_low_o,
  output logic [7:0]  trim_high_o
);

  logic [2:0]  calib_level_q;
  logic [7:0]  upper_q;

  logic        in_valid_q;
  logic        cmd_q;
  logic        ok_q;
  logic [7:0]  rlow_q;
  logic [7:0]  rhigh_q;

  ctss_state_t state_q;
  ctss_state_t state_d;
  logic        res_valid;
  ctss_res_t   res_d;
  ctss_res_t   res_q;
  logic        out_valid_q;

  logic        advance;
  logic        in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_level_q <= '0;
      upper_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgCalib: calib_level_q <= cfg_data_i[2:0];
        CfgUpper: upper_q       <= cfg_data_i;
        default:  upper_q       <= upper_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= cmd_i;
      ok_q    <= status_ok_i;
      rlow_q  <= read_low_i;
      rhigh_q <= read_high_i;
    end
  end

  ctss_step u_step (
    .state_i              (state_q),
    .calib_level_i        (calib_level_q),
    .upper_voltage_bits_i (upper_q),
    .cmd_i                (cmd_q),
    .status_ok_i          (ok_q),
    .read_low_i           (rlow_q),
    .read_high_i          (rhigh_q),
    .state_o              (state_d),
    .res_valid_o          (res_valid),
    .res_o                (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase  <= PH_IDLE;
      state_q.step   <= StLevel;
      state_q.down   <= 1'b0;
      state_q.offset <= '0;
      state_q.saved  <= '0;
      out_valid_q    <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign request_kind_o = res_q.kind;
  assign reg_address_o  = res_q.addr;
  assign write_byte_o   = res_q.wbyte;
  assign run_status_o   = res_q.status;
  assign trim_low_o     = res_q.trim_low;
  assign trim_high_o    = res_q.trim_high;

`ifndef ASSERT_OFF
  // a finished run never carries a request
  a_done_no_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (run_status_o != RS_BUSY) |-> request_kind_o == RQ_NONE)
    else $error("finished beat carries a request");

  // trim bytes stay clear while a run is busy
  a_busy_no_trim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (run_status_o == RS_BUSY) |-> trim_low_o == 8'd0 && trim_high_o == 8'd0)
    else $error("trim bytes set during a busy run");

  // input side only backs up when the result register is full and held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // search offset never passes the upward limit
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.offset <= UpLimit)
    else $error("trim offset out of range");
`endif

endmodule
